>>> design/gca_pkg.sv
`timescale 1ns / 1ps

package gca_pkg;

	localparam int PROC_IDX_W = 6;
	localparam int PROC_W     = 7;
	localparam int MASK_W     = 64;

	localparam logic [PROC_W-1:0] NO_PROC = 7'd64;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_RELEASE = 2'd1,
		OP_GRANT   = 2'd2,
		OP_REVOKE  = 2'd3
	} op_t;

endpackage

>>> design/gca_req_if.sv
`timescale 1ns / 1ps

interface gca_req_if;
	logic                              valid;
	logic                              ready;
	gca_pkg::op_t                      opcode;
	logic [gca_pkg::PROC_IDX_W-1:0]    proc_index;

	modport source (output valid, output opcode, output proc_index, input ready);
	modport sink   (input valid, input opcode, input proc_index, output ready);
endinterface

>>> design/gca_rsp_if.sv
`timescale 1ns / 1ps

interface gca_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [gca_pkg::PROC_W-1:0]    chosen_proc;
	logic                          none_free;
	logic                          give_back;
	logic                          op_error;
	logic [gca_pkg::PROC_W-1:0]    usable_count;
	logic [gca_pkg::MASK_W-1:0]    pending_mask;

	modport source (
		output valid, output chosen_proc, output none_free, output give_back,
		output op_error, output usable_count, output pending_mask, input ready
	);
	modport sink (
		input valid, input chosen_proc, input none_free, input give_back,
		input op_error, input usable_count, input pending_mask, output ready
	);
endinterface

>>> design/granted_core_allocator.sv
`timescale 1ns / 1ps

// Channel | Dir | Payload                                          | Handshake
// req     | in  | opcode, proc_index                               | valid/ready
// rsp     | out | chosen_proc, none_free, give_back, op_error,     | valid/ready
//         |     | usable_count, pending_mask                       |
//
// One request per cycle while the result is not stalled; each request is held in the request register,
// then its result is offered from the result register. The bitmap update and lowest-free search
// are combinational between those registers.
// Reset clears all bitmaps and counts at once; no clearing pass.
// While rsp.ready is low the result holds, the request register fills, then req.ready drops.

module granted_core_allocator #(
	parameter int NUM_PROCS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	gca_req_if.sink   req,
	gca_rsp_if.source rsp
);

	localparam int PW = gca_pkg::PROC_W;

	logic                              valid_s1;
	gca_pkg::op_t                      op_s1;
	logic [gca_pkg::PROC_IDX_W-1:0]    index_s1;

	logic [NUM_PROCS-1:0] granted_q, assigned_q, pending_q;
	logic [PW-1:0]        granted_cnt_q, pending_cnt_q;

	logic [NUM_PROCS-1:0] granted_d, assigned_d, pending_d;
	logic [PW-1:0]        granted_cnt_d, pending_cnt_d;

	logic                 out_valid_q;
	logic [PW-1:0]        chosen_q, usable_q;
	logic                 none_q, back_q, err_q;
	logic [gca_pkg::MASK_W-1:0] pmask_q;

	logic [PW-1:0]        chosen_d;
	logic                 none_d, back_d, err_d;

	logic [NUM_PROCS-1:0] sel, avail, first_oh;
	logic                 in_range, g_hit, a_hit, p_hit, first_found;
	logic [PW-1:0]        first_idx;
	logic                 advance;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// out-of-range index shifts past the top, leaving sel empty
	assign sel      = NUM_PROCS'(1) << index_s1;
	assign in_range = |sel;
	assign g_hit    = |(granted_q & sel);
	assign a_hit    = |(assigned_q & sel);
	assign p_hit    = |(pending_q & sel);
	assign avail    = granted_q & ~(assigned_q | pending_q);

	gca_first_set #(.WIDTH(NUM_PROCS)) u_first (
		.vec    (avail),
		.onehot (first_oh),
		.found  (first_found),
		.index  (first_idx)
	);

	always_comb begin
		granted_d     = granted_q;
		assigned_d    = assigned_q;
		pending_d     = pending_q;
		granted_cnt_d = granted_cnt_q;
		pending_cnt_d = pending_cnt_q;
		chosen_d      = gca_pkg::NO_PROC;
		none_d        = 1'b0;
		back_d        = 1'b0;
		err_d         = 1'b0;
		unique case (op_s1)
			gca_pkg::OP_ALLOC: begin
				if (!first_found) begin
					none_d = 1'b1;
				end else begin
					chosen_d   = first_idx;
					assigned_d = assigned_q | first_oh;
				end
			end
			gca_pkg::OP_RELEASE: begin
				if (!in_range || !g_hit || !a_hit) begin
					err_d = 1'b1;
				end else begin
					assigned_d = assigned_q & ~sel;
					if (p_hit) begin
						back_d        = 1'b1;
						pending_d     = pending_q & ~sel;
						granted_d     = granted_q & ~sel;
						granted_cnt_d = granted_cnt_q - PW'(1);
						pending_cnt_d = pending_cnt_q - PW'(1);
					end
				end
			end
			gca_pkg::OP_GRANT: begin
				if (!in_range || g_hit) begin
					err_d = 1'b1;
				end else begin
					granted_d     = granted_q | sel;
					granted_cnt_d = granted_cnt_q + PW'(1);
					if (p_hit) begin
						pending_d     = pending_q & ~sel;
						pending_cnt_d = pending_cnt_q - PW'(1);
					end
				end
			end
			gca_pkg::OP_REVOKE: begin
				if (!in_range || !g_hit) begin
					err_d = 1'b1;
				end else if (a_hit) begin
					// mark pending once; a repeat revoke changes nothing
					if (!p_hit) begin
						pending_d     = pending_q | sel;
						pending_cnt_d = pending_cnt_q + PW'(1);
					end
				end else begin
					granted_d     = granted_q & ~sel;
					granted_cnt_d = granted_cnt_q - PW'(1);
					back_d        = 1'b1;
				end
			end
			default: begin
				err_d = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.valid && req.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_s1    <= req.opcode;
			index_s1 <= req.proc_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			granted_q     <= '0;
			assigned_q    <= '0;
			pending_q     <= '0;
			granted_cnt_q <= '0;
			pending_cnt_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				granted_q     <= granted_d;
				assigned_q    <= assigned_d;
				pending_q     <= pending_d;
				granted_cnt_q <= granted_cnt_d;
				pending_cnt_q <= pending_cnt_d;
				out_valid_q   <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			chosen_q <= chosen_d;
			none_q   <= none_d;
			back_q   <= back_d;
			err_q    <= err_d;
			usable_q <= granted_cnt_d - pending_cnt_d;
			pmask_q  <= gca_pkg::MASK_W'(pending_d);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.chosen_proc  = chosen_q;
	assign rsp.none_free    = none_q;
	assign rsp.give_back    = back_q;
	assign rsp.op_error     = err_q;
	assign rsp.usable_count = usable_q;
	assign rsp.pending_mask = pmask_q;

endmodule

>>> design/gca_first_set.sv
`timescale 1ns / 1ps

module gca_first_set #(
	parameter int WIDTH = 64
) (
	input  logic [WIDTH-1:0]            vec,
	output logic [WIDTH-1:0]            onehot,
	output logic                        found,
	output logic [gca_pkg::PROC_W-1:0]  index
);

	// isolate the lowest set bit, then OR-encode its position
	assign onehot = vec & (~vec + WIDTH'(1));
	assign found  = |vec;

	always_comb begin
		index = '0;
		for (int i = 0; i < WIDTH; i++) begin
			if (onehot[i]) begin
				index = index | gca_pkg::PROC_W'(i);
			end
		end
		if (!found) begin
			index = gca_pkg::NO_PROC;
		end
	end

endmodule

>>> design/gca_checker.sv
`timescale 1ns / 1ps

module gca_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [gca_pkg::PROC_W-1:0]        chosen_proc,
	input logic                              none_free,
	input logic                              give_back,
	input logic                              op_error,
	input logic [gca_pkg::PROC_W-1:0]        usable_count,
	input logic [gca_pkg::MASK_W-1:0]        pending_mask
);

	// stalled result holds its payload
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(chosen_proc) && $stable(none_free)
			&& $stable(give_back) && $stable(op_error) && $stable(usable_count)
			&& $stable(pending_mask))
		else $error("result changed while stalled");

	a_none_no_proc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && none_free |-> chosen_proc == gca_pkg::NO_PROC)
		else $error("none_free with a chosen processor");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && op_error |-> !give_back && !none_free
			&& chosen_proc == gca_pkg::NO_PROC)
		else $error("error request reported side effects");

	a_chosen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && chosen_proc != gca_pkg::NO_PROC |-> !op_error && !none_free
			&& !give_back && chosen_proc < gca_pkg::NO_PROC)
		else $error("allocation result with conflicting flags");

endmodule

bind granted_core_allocator gca_checker u_gca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.chosen_proc  (rsp.chosen_proc),
	.none_free    (rsp.none_free),
	.give_back    (rsp.give_back),
	.op_error     (rsp.op_error),
	.usable_count (rsp.usable_count),
	.pending_mask (rsp.pending_mask)
);
